// ----- rtl/html_entity_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// html_entity_decoder_assert.svh - assertion macros
// Concurrent check shorthands clocked on aclk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef HTML_ENTITY_DECODER_ASSERT_SVH
`define HTML_ENTITY_DECODER_ASSERT_SVH

// follow-up check in the next cycle
`define HED_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("html_entity_decoder: check failed");

// follow-up check of c1 and then c2 in consecutive cycles
`define HED_ASSERT_NEXT2(lbl, ante, c1, c2) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (c1) ##1 (c2)) \
        else $error("html_entity_decoder: check failed");

`endif

// ----- rtl/hed_pkg.sv -----
// ----------------------------------------------------------------------------
// hed_pkg - shared types and constants
// Command and status words, character codes and the named reference table.
// ----------------------------------------------------------------------------
`default_nettype none

package hed_pkg;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    localparam logic [20:0] CP_LIMIT = 21'h110000;

    localparam int NAME_CNT = 15;
    localparam int KEY_MAX  = 6;

    // key bytes, first character in the low byte
    localparam logic [47:0] NAME_KEY [NAME_CNT] = '{
        48'h000000706d61, 48'h00000000746c, 48'h000000007467, 48'h0000746f7571,
        48'h0000736f7061, 48'h00007073626e, 48'h000079706f63, 48'h000000676572,
        48'h70696c6c6568, 48'h00687361646d, 48'h00687361646e, 48'h006f7571616c,
        48'h006f75716172, 48'h006564617274, 48'h000000676564
    };
    localparam logic [2:0] NAME_LEN [NAME_CNT] = '{
        3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd3
    };
    // UTF-8 bytes, first byte in the low byte
    localparam logic [23:0] NAME_UTF [NAME_CNT] = '{
        24'h000026, 24'h00003C, 24'h00003E, 24'h000022, 24'h000027, 24'h00A0C2,
        24'h00A9C2, 24'h00AEC2, 24'hA680E2, 24'h9480E2, 24'h9380E2, 24'h00ABC2,
        24'h00BBC2, 24'hA284E2, 24'h00B0C2
    };
    localparam logic [2:0] NAME_ULEN [NAME_CNT] = '{
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd2
    };

    typedef struct packed {
        logic accept;
        logic feed;
        logic fail;
        logic emit;
        logic flush;
    } hed_cmd_t;

    typedef struct packed {
        logic pend_zero;
        logic in_ref;
        logic emit_busy;
        logic emit_ok;
        logic hold_v;
        logic out_free;
        logic last_step;
    } hed_stat_t;

endpackage

`default_nettype wire

// ----- rtl/html_entity_decoder.sv -----
// ----------------------------------------------------------------------------
// html_entity_decoder - streaming HTML character reference decoder
// Decodes numeric and named references in a byte stream into UTF-8 bytes.
//
//   channel   dir   handshake            payload
//   s_        in    s_tvalid / s_tready  s_tdata = in_byte, s_tlast = in_last
//   m_        out   m_tvalid / m_tready  m_tdata = out_byte, m_tlast = out_last
//
// One input word passes through accept, feed, end check and flush, plus a
// replay step per byte after a failed reference, an emit step per UTF-8 byte
// of a decoded reference and a fail step per reference failed at end of text.
// Unless m_ stalls, a single feed path reads the window buffer a byte per cycle.
// Reset clears all control state; no clearing pass is needed.
// A stalled m_ side holds the sequencer at its next output byte.
// ----------------------------------------------------------------------------
`default_nettype none

module html_entity_decoder import hed_pkg::*; #(
    parameter int WINDOW_LEN = 12
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast
);

    hed_cmd_t  cmd;
    hed_stat_t stat;

    hed_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hed_datapath #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/hed_ctrl.sv -----
// ----------------------------------------------------------------------------
// hed_ctrl - decoder sequencer
// Accepts a word, steps the datapath through feed, fail and emit, then flushes.
// ----------------------------------------------------------------------------
`default_nettype none

module hed_ctrl import hed_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  hed_stat_t      stat,
    output hed_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_FLUSH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) state_next = S_RUN;
            end
            S_RUN: begin
                if (stat.emit_busy) begin
                    cmd.emit = stat.emit_ok;
                end else if (!stat.pend_zero) begin
                    cmd.feed = stat.emit_ok;
                end else if (stat.last_step && stat.in_ref) begin
                    cmd.fail = stat.emit_ok;
                end else begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!stat.hold_v) begin
                    state_next = S_IDLE;
                end else if (stat.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ----- rtl/hed_datapath.sv -----
// ----------------------------------------------------------------------------
// hed_datapath - window buffer, reference parser and output stage
// Circular byte buffer, incremental numeric and name match, UTF-8 result shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module hed_datapath import hed_pkg::*; #(
    parameter int WINDOW_LEN = 12
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    input  hed_cmd_t        cmd,
    output hed_stat_t       stat,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    localparam int PW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FW = $clog2(WINDOW_LEN + 1);
    localparam int EW = FW + 1;
    localparam logic [PW-1:0] LAST_IDX = PW'(WINDOW_LEN - 1);
    localparam logic [FW-1:0] FULL     = FW'(WINDOW_LEN);

    typedef enum logic [8:0] {
        NS_HASH = 9'b000000001,
        NS_BASE = 9'b000000010,
        NS_WS   = 9'b000000100,
        NS_PREF = 9'b000001000,
        NS_ZERO = 9'b000010000,
        NS_PFX2 = 9'b000100000,
        NS_DIG  = 9'b001000000,
        NS_DONE = 9'b010000000,
        NS_DEAD = 9'b100000000
    } nstate_t;

    logic [7:0]          win_reg [WINDOW_LEN];
    logic [PW-1:0]       rptr_reg, rptr_next;
    logic [FW-1:0]       pend_reg, pend_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic                in_ref_reg, in_ref_next;
    logic                last_reg, last_next;
    nstate_t             nst_reg, nst_next;
    logic                hex_reg, hex_next;
    logic                neg_reg, neg_next;
    logic [20:0]         val_reg, val_next;
    logic [NAME_CNT-1:0] alive_reg, alive_next;
    logic [31:0]         emit_sh_reg, emit_sh_next;
    logic [2:0]          emit_cnt_reg, emit_cnt_next;
    logic                hold_v_reg, hold_v_next;
    logic [7:0]          hold_byte_reg, hold_byte_next;
    logic                out_v_reg, out_v_next;
    logic [7:0]          out_byte_reg, out_byte_next;
    logic                out_last_reg, out_last_next;

    logic [7:0]          b;
    logic [PW-1:0]       rptr_inc, rptr_back;
    logic [EW-1:0]       rp_ext, fl_ext, back_ext;
    logic [FW-1:0]       fill_inc;
    logic                is_amp, is_semi, is_x, is_ws, is_sign, is_dec, is_hex, dig_ok;
    logic [3:0]          dval;
    logic [24:0]         prod, sum;
    logic [20:0]         sat;
    logic                go_ws, go_pref, go_dig;
    nstate_t             pn_nst;
    logic                pn_hex, pn_neg;
    logic [20:0]         pn_val;
    logic [NAME_CNT-1:0] pn_alive;
    logic                num_ok, name_hit, ref_ok, fail_now;
    logic [3:0]          name_sel;
    logic [31:0]         num_sh, ok_sh;
    logic [2:0]          num_len, ok_len;
    logic                emit_en, push, out_free;
    logic [7:0]          emit_byte;

    assign b        = win_reg[rptr_reg];
    assign rptr_inc = (rptr_reg == LAST_IDX) ? '0 : rptr_reg + 1'b1;
    assign rp_ext   = EW'(rptr_reg);
    assign fl_ext   = EW'(fill_reg);
    assign back_ext = (rp_ext >= fl_ext) ? rp_ext - fl_ext : rp_ext + EW'(WINDOW_LEN) - fl_ext;
    assign rptr_back = back_ext[PW-1:0];
    assign fill_inc = fill_reg + 1'b1;

    assign is_amp  = (b == CH_AMP);
    assign is_semi = (b == CH_SEMI);
    assign is_x    = (b == CH_LX) || (b == CH_UX);
    assign is_ws   = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    assign is_sign = (b == CH_PLUS) || (b == CH_MINUS);
    assign is_dec  = (b >= 8'h30 && b <= 8'h39);
    assign is_hex  = is_dec || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
    assign dig_ok  = hex_reg ? is_hex : is_dec;
    assign dval    = is_dec ? b[3:0] : b[3:0] + 4'd9;
    assign prod    = hex_reg ? {val_reg, 4'b0000} : {1'b0, val_reg, 3'b000} + {3'b000, val_reg, 1'b0};
    assign sum     = prod + 25'(dval);
    assign sat     = (sum > 25'(CP_LIMIT)) ? CP_LIMIT : sum[20:0];

    always_comb begin
        go_ws   = 1'b0;
        go_pref = 1'b0;
        go_dig  = 1'b0;
        pn_nst  = nst_reg;
        pn_hex  = hex_reg;
        pn_neg  = neg_reg;
        pn_val  = val_reg;
        unique case (nst_reg)
            NS_HASH: pn_nst = (b == CH_HASH) ? NS_BASE : NS_DEAD;
            NS_BASE: begin
                if (is_x) begin
                    pn_hex = 1'b1;
                    pn_nst = NS_WS;
                end else begin
                    go_ws = 1'b1;
                end
            end
            NS_WS:   go_ws = 1'b1;
            NS_PREF: go_pref = 1'b1;
            NS_ZERO: begin
                if (is_x) pn_nst = NS_PFX2;
                else      go_dig = 1'b1;
            end
            NS_PFX2: go_dig = 1'b1;
            NS_DIG:  go_dig = 1'b1;
            default: ;
        endcase
        if (go_ws) begin
            if (is_ws) begin
                pn_nst = NS_WS;
            end else if (is_sign) begin
                pn_neg = (b == CH_MINUS);
                pn_nst = pn_hex ? NS_PREF : NS_DIG;
            end else if (pn_hex) begin
                go_pref = 1'b1;
            end else begin
                go_dig = 1'b1;
            end
        end
        if (go_pref) begin
            if (b == CH_ZERO) pn_nst = NS_ZERO;
            else              go_dig = 1'b1;
        end
        if (go_dig) begin
            if (dig_ok) begin
                pn_val = sat;
                pn_nst = NS_DIG;
            end else begin
                pn_nst = NS_DONE;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NAME_CNT; k++) begin
            pn_alive[k] = alive_reg[k] && (fill_reg < FW'(KEY_MAX)) &&
                          (NAME_KEY[k][{fill_reg[2:0], 3'b000} +: 8] == b);
        end
    end

    always_comb begin
        name_hit = 1'b0;
        name_sel = '0;
        for (int k = NAME_CNT - 1; k >= 0; k--) begin
            if (alive_reg[k] && (fill_reg == FW'(NAME_LEN[k]))) begin
                name_hit = 1'b1;
                name_sel = 4'(k);
            end
        end
    end

    assign num_ok = !neg_reg && (val_reg != '0) && (val_reg < CP_LIMIT);

    always_comb begin
        if (val_reg < 21'h80) begin
            num_sh  = {24'h0, val_reg[7:0]};
            num_len = 3'd1;
        end else if (val_reg < 21'h800) begin
            num_sh  = {16'h0, 2'b10, val_reg[5:0], 3'b110, val_reg[10:6]};
            num_len = 3'd2;
        end else if (val_reg < 21'h10000) begin
            num_sh  = {8'h0, 2'b10, val_reg[5:0], 2'b10, val_reg[11:6], 4'hE, val_reg[15:12]};
            num_len = 3'd3;
        end else begin
            num_sh  = {2'b10, val_reg[5:0], 2'b10, val_reg[11:6], 2'b10, val_reg[17:12],
                       5'b11110, val_reg[20:18]};
            num_len = 3'd4;
        end
    end

    assign ok_sh    = num_ok ? num_sh : {8'h0, NAME_UTF[name_sel]};
    assign ok_len   = num_ok ? num_len : NAME_ULEN[name_sel];
    assign ref_ok   = num_ok || name_hit;
    assign fail_now = is_semi ? !ref_ok : (fill_inc == FULL);

    assign out_free = !out_v_reg || m_tready;

    always_comb begin
        rptr_next     = rptr_reg;
        pend_next     = pend_reg;
        fill_next     = fill_reg;
        in_ref_next   = in_ref_reg;
        last_next     = last_reg;
        nst_next      = nst_reg;
        hex_next      = hex_reg;
        neg_next      = neg_reg;
        val_next      = val_reg;
        alive_next    = alive_reg;
        emit_sh_next  = emit_sh_reg;
        emit_cnt_next = emit_cnt_reg;
        emit_en       = 1'b0;
        emit_byte     = b;
        if (cmd.accept) begin
            pend_next = FW'(1);
            last_next = s_tlast;
        end
        if (cmd.feed) begin
            rptr_next = rptr_inc;
            pend_next = pend_reg - 1'b1;
            if (!in_ref_reg) begin
                if (is_amp) begin
                    in_ref_next = 1'b1;
                    fill_next   = '0;
                    nst_next    = NS_HASH;
                    hex_next    = 1'b0;
                    neg_next    = 1'b0;
                    val_next    = '0;
                    alive_next  = '1;
                end else begin
                    emit_en = 1'b1;
                end
            end else if (fail_now) begin
                emit_en     = 1'b1;
                emit_byte   = CH_AMP;
                rptr_next   = rptr_back;
                pend_next   = pend_reg + fill_reg;
                in_ref_next = 1'b0;
                fill_next   = '0;
            end else if (is_semi) begin
                in_ref_next   = 1'b0;
                fill_next     = '0;
                emit_sh_next  = ok_sh;
                emit_cnt_next = ok_len;
            end else begin
                fill_next  = fill_inc;
                nst_next   = pn_nst;
                hex_next   = pn_hex;
                neg_next   = pn_neg;
                val_next   = pn_val;
                alive_next = pn_alive;
            end
        end
        if (cmd.fail) begin
            emit_en     = 1'b1;
            emit_byte   = CH_AMP;
            rptr_next   = rptr_back;
            pend_next   = pend_reg + fill_reg;
            in_ref_next = 1'b0;
            fill_next   = '0;
        end
        if (cmd.emit) begin
            emit_en       = 1'b1;
            emit_byte     = emit_sh_reg[7:0];
            emit_sh_next  = emit_sh_reg >> 8;
            emit_cnt_next = emit_cnt_reg - 1'b1;
        end
    end

    assign push = hold_v_reg && (emit_en || cmd.flush);

    always_comb begin
        hold_v_next    = hold_v_reg;
        hold_byte_next = hold_byte_reg;
        out_v_next     = out_v_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (emit_en) begin
            hold_v_next    = 1'b1;
            hold_byte_next = emit_byte;
        end
        if (cmd.flush) hold_v_next = 1'b0;
        if (push) begin
            out_v_next    = 1'b1;
            out_byte_next = hold_byte_reg;
            out_last_next = cmd.flush && last_reg;
        end else if (m_tready) begin
            out_v_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) win_reg[rptr_reg] <= s_tdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rptr_reg     <= '0;
            pend_reg     <= '0;
            fill_reg     <= '0;
            in_ref_reg   <= 1'b0;
            last_reg     <= 1'b0;
            emit_cnt_reg <= '0;
            hold_v_reg   <= 1'b0;
            out_v_reg    <= 1'b0;
        end else begin
            rptr_reg     <= rptr_next;
            pend_reg     <= pend_next;
            fill_reg     <= fill_next;
            in_ref_reg   <= in_ref_next;
            last_reg     <= last_next;
            emit_cnt_reg <= emit_cnt_next;
            hold_v_reg   <= hold_v_next;
            out_v_reg    <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        nst_reg       <= nst_next;
        hex_reg       <= hex_next;
        neg_reg       <= neg_next;
        val_reg       <= val_next;
        alive_reg     <= alive_next;
        emit_sh_reg   <= emit_sh_next;
        hold_byte_reg <= hold_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign stat.pend_zero = (pend_reg == '0);
    assign stat.in_ref    = in_ref_reg;
    assign stat.emit_busy = (emit_cnt_reg != '0);
    assign stat.emit_ok   = !hold_v_reg || out_free;
    assign stat.hold_v    = hold_v_reg;
    assign stat.out_free  = out_free;
    assign stat.last_step = last_reg;

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/hed_checker.sv -----
// ----------------------------------------------------------------------------
// hed_checker - port checks for the decoder
// Watches the stream handshakes of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "html_entity_decoder_assert.svh"

module hed_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready
);

    `HED_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `HED_ASSERT_NEXT2(a_busy_after_word, s_tvalid && s_tready, !s_tready, !s_tready)
    `HED_ASSERT_NEXT(a_idle_stays_ready, s_tready && !s_tvalid, s_tready)

endmodule

bind html_entity_decoder hed_checker u_hed_checker (.*);

`default_nettype wire
